/* src/hsps_pkg.sv */
// Shared constants, codes and control types of the hot slice pin selector.
package hsps_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned ScanW   = IdxW + 1;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CntW    = 32;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned TotW    = 24;
  localparam int unsigned NumW    = 9;
  localparam int unsigned WarmW   = 16;
  localparam int unsigned StW     = 2;
  localparam int unsigned ScoreW  = CntW + 1;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CmdW-1:0] CMD_TRACK = 3'd0;
  localparam logic [CmdW-1:0] CMD_DECAY = 3'd1;
  localparam logic [CmdW-1:0] CMD_REBAL = 3'd2;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd3;
  localparam logic [CmdW-1:0] CMD_DROP  = 3'd4;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_NOREG = 2'd1;
  localparam logic [StW-1:0] ST_SKIP  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_BUDGET = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_WARMUP = 1'd1;

  typedef struct packed {
    logic start;
    logic exec;
    logic decay;
    logic rb_scan;
    logic rb_pick;
    logic rb_apply;
    logic fin;
  } hsps_ctl_t;

  typedef struct packed {
    logic out_free;
    logic idx_last;
    logic found;
    logic rb_skip;
  } hsps_sts_t;

endpackage

/* src/hsps_if.sv */
// Channel interfaces of the hot slice pin selector.
interface hsps_item_if import hsps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [IdxW-1:0]  entry;
  logic             used;
  logic [SizeW-1:0] slice_pages;
  logic             call_end;
  modport source (output valid, cmd, entry, used, slice_pages, call_end, input ready);
  modport sink (input valid, cmd, entry, used, slice_pages, call_end, output ready);
endinterface

interface hsps_result_if import hsps_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [StW-1:0]  status;
  logic [CntW-1:0] use_count;
  logic            is_pinned;
  logic [TotW-1:0] total_pinned_pages;
  logic [NumW-1:0] newly_pinned;
  logic [NumW-1:0] newly_unpinned;
  modport source (output valid, status, use_count, is_pinned, total_pinned_pages,
                  newly_pinned, newly_unpinned, input ready);
  modport sink (input valid, status, use_count, is_pinned, total_pinned_pages,
                newly_pinned, newly_unpinned, output ready);
endinterface

interface hsps_cfg_if import hsps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CntW-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/hsps_ram.sv */
// Generic RAM with one write port and one registered read port.
module hsps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/hsps_ctrl.sv */
// Controller state machine that sequences commands, table walks and result delivery.
module hsps_ctrl import hsps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [CmdW-1:0] in_cmd_i,
  output logic            in_ready_o,
  input  hsps_sts_t       sts_i,
  output hsps_ctl_t       ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DEC, S_RB_SCAN, S_RB_PICK, S_RB_APPLY, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          if (in_cmd_i == CMD_DECAY) begin
            state_d = S_DEC;
          end else if (in_cmd_i == CMD_REBAL && !sts_i.rb_skip) begin
            state_d = S_RB_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          ctl_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DEC: begin
        ctl_o.decay = 1'b1;
        if (sts_i.idx_last) state_d = S_FIN;
      end
      S_RB_SCAN: begin
        ctl_o.rb_scan = 1'b1;
        if (sts_i.idx_last) state_d = S_RB_PICK;
      end
      S_RB_PICK: begin
        ctl_o.rb_pick = 1'b1;
        state_d = sts_i.found ? S_RB_SCAN : S_RB_APPLY;
      end
      S_RB_APPLY: begin
        ctl_o.rb_apply = 1'b1;
        if (sts_i.idx_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/hsps_dp.sv */
// Datapath with the entry tables, rebalance walk registers and result register.
module hsps_dp import hsps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hsps_ctl_t          ctl_i,
  output hsps_sts_t          sts_o,
  input  logic [CmdW-1:0]    in_cmd_i,
  input  logic [IdxW-1:0]    in_entry_i,
  input  logic               in_used_i,
  input  logic [SizeW-1:0]   in_pages_i,
  input  logic               in_call_end_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StW-1:0]     out_status_o,
  output logic [CntW-1:0]    out_count_o,
  output logic               out_pinned_o,
  output logic [TotW-1:0]    out_total_o,
  output logic [NumW-1:0]    out_np_o,
  output logic [NumW-1:0]    out_nu_o
);

  localparam logic [CntW-1:0]  CntMax  = '1;
  localparam logic [ScanW-1:0] ScanEnd = ScanW'(Entries);

  logic [CmdW-1:0]    cmd_q;
  logic [IdxW-1:0]    ent_q;
  logic               used_q, cend_q;
  logic [SizeW-1:0]   pages_q;
  logic [Entries-1:0] valid_q, valid_d, pinned_q, pinned_d;
  logic [Entries-1:0] visited_q, visited_d, keep_q, keep_d;
  logic [CntW-1:0]    call_q, call_d;
  logic [TotW-1:0]    budget_q, total_q, total_d, want_q, want_d;
  logic [WarmW-1:0]   warmup_q;
  logic [NumW-1:0]    np_q, np_d, nu_q, nu_d;
  logic [ScoreW-1:0]  best_q, best_d;
  logic [IdxW-1:0]    bidx_q, bidx_d;
  logic [SizeW-1:0]   bsize_q, bsize_d;
  logic               found_q, found_d;
  logic [ScanW-1:0]   idx_q, idx_d;
  logic               out_v_q, out_v_d;
  logic [StW-1:0]     ost_q, ost_d;
  logic [CntW-1:0]    ocnt_q, ocnt_d;
  logic               opin_q, opin_d;
  logic [TotW-1:0]    otot_q, otot_d;
  logic [NumW-1:0]    onp_q, onp_d, onu_q, onu_d;

  logic               scanning, cnt_we, size_we, e_valid;
  logic [IdxW-1:0]    raddr, jj, cnt_waddr;
  logic [CntW-1:0]    cnt_rd, cnt_wdata, cur_cnt, new_cnt;
  logic [SizeW-1:0]   size_rd;
  logic [ScoreW-1:0]  score;
  logic [TotW:0]      want_sum;

  assign scanning = ctl_i.decay | ctl_i.rb_scan | ctl_i.rb_apply;
  assign jj       = IdxW'(idx_q - ScanW'(1));
  assign raddr    = ctl_i.start ? in_entry_i : (scanning ? idx_q[IdxW-1:0] : ent_q);
  assign e_valid  = valid_q[ent_q];
  assign cur_cnt  = e_valid ? cnt_rd : '0;
  assign new_cnt  = (used_q && cur_cnt != CntMax) ? cur_cnt + CntW'(1) : cur_cnt;
  assign score    = {1'b0, cnt_rd} + (pinned_q[jj] ? {4'd0, cnt_rd[CntW-1:3]} : '0);
  assign want_sum = {1'b0, want_q} + (TotW+1)'(bsize_q);

  hsps_ram #(.Width(CntW), .Depth(Entries)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(raddr), .rdata_o(cnt_rd)
  );

  hsps_ram #(.Width(SizeW), .Depth(Entries)) u_size_ram (
    .clk_i, .we_i(size_we), .waddr_i(ent_q), .wdata_i(pages_q),
    .raddr_i(raddr), .rdata_o(size_rd)
  );

  always_comb begin
    valid_d   = valid_q;
    pinned_d  = pinned_q;
    visited_d = visited_q;
    keep_d    = keep_q;
    call_d    = call_q;
    total_d   = total_q;
    want_d    = want_q;
    np_d      = np_q;
    nu_d      = nu_q;
    best_d    = best_q;
    bidx_d    = bidx_q;
    bsize_d   = bsize_q;
    found_d   = found_q;
    idx_d     = idx_q;
    out_v_d   = out_v_q & ~out_ready_i;
    ost_d     = ost_q;
    ocnt_d    = ocnt_q;
    opin_d    = opin_q;
    otot_d    = otot_q;
    onp_d     = onp_q;
    onu_d     = onu_q;
    cnt_we    = 1'b0;
    size_we   = 1'b0;
    cnt_waddr = ent_q;
    cnt_wdata = new_cnt;

    if (ctl_i.start) begin
      visited_d = '0;
      keep_d    = '0;
      want_d    = '0;
      found_d   = 1'b0;
      np_d      = '0;
      nu_d      = '0;
      idx_d     = '0;
    end

    if (scanning) begin
      idx_d = (idx_q == ScanEnd) ? '0 : idx_q + ScanW'(1);
    end

    if (ctl_i.decay && idx_q != '0) begin
      cnt_we    = 1'b1;
      cnt_waddr = jj;
      cnt_wdata = cnt_rd >> 1;
    end

    if (ctl_i.rb_scan && idx_q != '0) begin
      if (valid_q[jj] && (cnt_rd != '0 || pinned_q[jj]) && !visited_q[jj] &&
          (!found_q || score > best_q)) begin
        found_d = 1'b1;
        best_d  = score;
        bidx_d  = jj;
        bsize_d = size_rd;
      end
    end

    if (ctl_i.rb_pick && found_q) begin
      found_d           = 1'b0;
      visited_d[bidx_q] = 1'b1;
      if (want_sum <= {1'b0, budget_q}) begin
        want_d         = want_sum[TotW-1:0];
        keep_d[bidx_q] = bsize_q != '0;
      end
    end

    if (ctl_i.rb_apply && idx_q != '0) begin
      if (pinned_q[jj] && !keep_q[jj]) begin
        pinned_d[jj] = 1'b0;
        total_d      = total_q - TotW'(size_rd);
        nu_d         = nu_q + NumW'(1);
      end else if (!pinned_q[jj] && keep_q[jj]) begin
        pinned_d[jj] = 1'b1;
        total_d      = total_q + TotW'(size_rd);
        np_d         = np_q + NumW'(1);
      end
    end

    if (ctl_i.exec) begin
      out_v_d = 1'b1;
      ost_d   = ST_OK;
      ocnt_d  = '0;
      opin_d  = 1'b0;
      onp_d   = '0;
      onu_d   = '0;
      case (cmd_q)
        CMD_TRACK: begin
          if (cend_q && call_q != CntMax) call_d = call_q + CntW'(1);
          cnt_we = 1'b1;
          if (!e_valid) begin
            size_we         = 1'b1;
            valid_d[ent_q]  = 1'b1;
            pinned_d[ent_q] = 1'b0;
          end
          ocnt_d = new_cnt;
          opin_d = e_valid & pinned_q[ent_q];
        end
        CMD_READ: begin
          if (e_valid) begin
            ocnt_d = cur_cnt;
            opin_d = pinned_q[ent_q];
          end else begin
            ost_d = ST_NOREG;
          end
        end
        CMD_DROP: begin
          if (e_valid) begin
            if (pinned_q[ent_q]) total_d = total_q - TotW'(size_rd);
            valid_d[ent_q]  = 1'b0;
            pinned_d[ent_q] = 1'b0;
          end else begin
            ost_d = ST_NOREG;
          end
        end
        CMD_REBAL: ost_d = ST_SKIP;
        default: ost_d = ST_OK;
      endcase
      otot_d = total_d;
    end

    if (ctl_i.fin) begin
      out_v_d = 1'b1;
      ost_d   = ST_OK;
      ocnt_d  = '0;
      opin_d  = 1'b0;
      otot_d  = total_q;
      onp_d   = np_q;
      onu_d   = nu_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      pinned_q  <= '0;
      visited_q <= '0;
      keep_q    <= '0;
      call_q    <= '0;
      total_q   <= '0;
      want_q    <= '0;
      np_q      <= '0;
      nu_q      <= '0;
      found_q   <= 1'b0;
      idx_q     <= '0;
      out_v_q   <= 1'b0;
      budget_q  <= TotW'(1048576);
      warmup_q  <= WarmW'(100);
    end else begin
      valid_q   <= valid_d;
      pinned_q  <= pinned_d;
      visited_q <= visited_d;
      keep_q    <= keep_d;
      call_q    <= call_d;
      total_q   <= total_d;
      want_q    <= want_d;
      np_q      <= np_d;
      nu_q      <= nu_d;
      found_q   <= found_d;
      idx_q     <= idx_d;
      out_v_q   <= out_v_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_BUDGET: budget_q <= cfg_data_i[TotW-1:0];
          REG_WARMUP: warmup_q <= cfg_data_i[WarmW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    bsize_q <= bsize_d;
    ost_q   <= ost_d;
    ocnt_q  <= ocnt_d;
    opin_q  <= opin_d;
    otot_q  <= otot_d;
    onp_q   <= onp_d;
    onu_q   <= onu_d;
    if (ctl_i.start) begin
      cmd_q   <= in_cmd_i;
      ent_q   <= in_entry_i;
      used_q  <= in_used_i;
      pages_q <= in_pages_i;
      cend_q  <= in_call_end_i;
    end
  end

  assign sts_o.out_free = ~out_v_q | out_ready_i;
  assign sts_o.idx_last = idx_q == ScanEnd;
  assign sts_o.found    = found_q;
  assign sts_o.rb_skip  = (budget_q == '0) || (call_q < CntW'(warmup_q));

  assign out_valid_o  = out_v_q;
  assign out_status_o = ost_q;
  assign out_count_o  = ocnt_q;
  assign out_pinned_o = opin_q;
  assign out_total_o  = otot_q;
  assign out_np_o     = onp_q;
  assign out_nu_o     = onu_q;

endmodule

/* src/hot_slice_pin_selector_core.sv */
// Top level of the hot slice pin selector: a use-count hot set with aging and pin selection.
// Commands arrive as words on item_i and each one yields exactly one word on result_o.
// Configuration words on cfg_i set the pin budget (index 0) and the warm-up call count
// (index 1); cfg_i is always ready. The user must write cfg_i only while the block is
// idle; the block itself does not enforce this. Track, read, drop, unknown commands
// and skipped rebalances read the count and size tables in the accept cycle; S_EXEC
// then updates them and loads the result register once the output register is free.
// A decay walks all 256 table entries through the count memory port. A rebalance
// makes one selection pass for each candidate entry plus one final empty pass, each
// followed by a pick step, then an apply pass and the result step; a candidate is a
// valid entry with a nonzero count or a pin. One command is worked on at a time.
// Reset clears the valid and pinned marks, the pinned total and the call counter, and
// restores the register defaults; the tables need no clearing pass. While the receiver
// stalls, the finished word waits in the output register; a new command may be accepted
// meanwhile but its result is held back until the pending word is taken.
module hot_slice_pin_selector_core import hsps_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsps_item_if.sink      item_i,
  hsps_result_if.source  result_o,
  hsps_cfg_if.sink       cfg_i
);

  hsps_ctl_t ctl;
  hsps_sts_t sts;

  assign cfg_i.ready = 1'b1;

  hsps_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (item_i.valid),
    .in_cmd_i   (item_i.cmd),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  hsps_dp u_dp (
    .clk_i,
    .rst_ni,
    .ctl_i         (ctl),
    .sts_o         (sts),
    .in_cmd_i      (item_i.cmd),
    .in_entry_i    (item_i.entry),
    .in_used_i     (item_i.used),
    .in_pages_i    (item_i.slice_pages),
    .in_call_end_i (item_i.call_end),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_status_o  (result_o.status),
    .out_count_o   (result_o.use_count),
    .out_pinned_o  (result_o.is_pinned),
    .out_total_o   (result_o.total_pinned_pages),
    .out_np_o      (result_o.newly_pinned),
    .out_nu_o      (result_o.newly_unpinned)
  );

endmodule

/* tb/hot_slice_pin_selector_core_test.sv */
// Testbench of hot_slice_pin_selector_core: random and directed commands checked against a predictor.
module hot_slice_pin_selector_core_test;
  import hsps_pkg::*;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  entry;
    logic             used;
    logic [SizeW-1:0] pages;
    logic             call_end;
  } hot_cmd_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [CntW-1:0] use_count;
    logic            is_pinned;
    logic [TotW-1:0] total;
    logic [NumW-1:0] pins;
    logic [NumW-1:0] unpins;
  } pin_result_t;

  class pin_scoreboard;
    bit [CntW-1:0]  counts[Entries];
    bit             pinned[Entries];
    bit             live[Entries];
    bit [SizeW-1:0] sizes[Entries];
    bit [TotW-1:0]  total;
    bit [CntW-1:0]  calls;
    bit [TotW-1:0]  budget;
    bit [WarmW-1:0] warmup;
    pin_result_t    awaited[$];

    function new();
      foreach (counts[i]) begin
        counts[i] = '0;
        pinned[i] = 1'b0;
        live[i] = 1'b0;
        sizes[i] = '0;
      end
      total = '0;
      calls = '0;
      budget = 24'd1048576;
      warmup = 16'd100;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
      if (idx == REG_BUDGET) budget = data[TotW-1:0];
      else warmup = data[WarmW-1:0];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void select_pins(output int np, output int nu);
      bit [ScoreW-1:0] score[Entries];
      int order[Entries];
      bit keep[Entries];
      bit [ScoreW-1:0] s;
      longint unsigned want;
      int n, j;
      n = 0;
      want = 0;
      for (int i = 0; i < Entries; i++) begin
        keep[i] = 1'b0;
        if (live[i] && (counts[i] != 0 || pinned[i])) begin
          s = {1'b0, counts[i]} + (pinned[i] ? {4'b0, counts[i][CntW-1:3]} : '0);
          j = n;
          while (j > 0 && score[j-1] < s) begin
            score[j] = score[j-1];
            order[j] = order[j-1];
            j--;
          end
          score[j] = s;
          order[j] = i;
          n++;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (want + sizes[order[i]] <= budget) begin
          want += sizes[order[i]];
          keep[order[i]] = sizes[order[i]] != 0;
        end
      end
      np = 0;
      nu = 0;
      for (int i = 0; i < Entries; i++) begin
        if (live[i] && pinned[i] && !keep[i]) begin
          pinned[i] = 1'b0;
          total -= sizes[i];
          nu++;
        end else if (live[i] && !pinned[i] && keep[i]) begin
          pinned[i] = 1'b1;
          total += sizes[i];
          np++;
        end
      end
    endfunction

    function void note(hot_cmd_t c);
      pin_result_t r;
      int np, nu;
      r = '0;
      np = 0;
      nu = 0;
      case (c.cmd)
        CMD_TRACK: begin
          if (c.call_end && calls != '1) calls++;
          if (!live[c.entry]) begin
            live[c.entry] = 1'b1;
            counts[c.entry] = '0;
            pinned[c.entry] = 1'b0;
            sizes[c.entry] = c.pages;
          end
          if (c.used && counts[c.entry] != '1) counts[c.entry]++;
          r.use_count = counts[c.entry];
          r.is_pinned = pinned[c.entry];
        end
        CMD_DECAY: foreach (counts[i]) counts[i] = counts[i] >> 1;
        CMD_REBAL: begin
          if (budget == 0 || calls < warmup) r.status = ST_SKIP;
          else select_pins(np, nu);
        end
        CMD_READ, CMD_DROP: begin
          if (live[c.entry]) begin
            if (c.cmd == CMD_DROP) begin
              if (pinned[c.entry]) total -= sizes[c.entry];
              live[c.entry] = 1'b0;
              pinned[c.entry] = 1'b0;
              counts[c.entry] = '0;
              sizes[c.entry] = '0;
            end
            r.use_count = counts[c.entry];
            r.is_pinned = pinned[c.entry];
          end else begin
            r.status = ST_NOREG;
          end
        end
        default: ;
      endcase
      r.total = total;
      r.pins = np[NumW-1:0];
      r.unpins = nu[NumW-1:0];
      awaited = {awaited, r};
    endfunction

    // Returns 0 on a match, 1 with nothing awaited, 2 on a mismatch.
    function int check(pin_result_t got, output pin_result_t want);
      want = '0;
      if (awaited.size() == 0) return 1;
      want = awaited.pop_front();
      return (got == want) ? 0 : 2;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsps_item_if   item ();
  hsps_result_if res ();
  hsps_cfg_if    cfg ();

  hot_slice_pin_selector_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .result_o (res),
    .cfg_i    (cfg)
  );

  always #5 clk_i = ~clk_i;

  pin_scoreboard sb = new();
  int errors = 0;
  int accepted = 0;
  int src_pct = 0;
  int snk_pct = 0;
  int hold_left = 0;
  bit held = 1'b0;

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Receiver; one long hold-off lets the block fill up and stall its input.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && accepted >= 400) begin
        held = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready = 1'b0;
      end else begin
        res.ready = $urandom_range(99) >= snk_pct;
      end
    end
  end

  always @(posedge clk_i) begin
    pin_result_t got, want;
    int rc;
    if (rst_ni && res.valid && res.ready) begin
      got = {res.status, res.use_count, res.is_pinned, res.total_pinned_pages,
             res.newly_pinned, res.newly_unpinned};
      rc = sb.check(got, want);
      if (rc == 1) report("result word with nothing awaited");
      else if (rc == 2)
        report($sformatf({"got st %0d cnt %0d pin %0d tot %0d np %0d nu %0d, ",
                          "want %0d %0d %0d %0d %0d %0d"},
                         got.status, got.use_count, got.is_pinned, got.total, got.pins,
                         got.unpins, want.status, want.use_count, want.is_pinned,
                         want.total, want.pins, want.unpins));
    end
  end

  task automatic send_cmd(hot_cmd_t c);
    @(negedge clk_i);
    while ($urandom_range(99) < src_pct) begin
      item.valid = 1'b0;
      @(negedge clk_i);
    end
    item.valid = 1'b1;
    item.cmd = c.cmd;
    item.entry = c.entry;
    item.used = c.used;
    item.slice_pages = c.pages;
    item.call_end = c.call_end;
    @(posedge clk_i);
    while (!item.ready) @(posedge clk_i);
    sb.note(c);
    accepted++;
  endtask

  task automatic send_fields(logic [CmdW-1:0] cmd, int entry, bit used, int pages, bit ce);
    hot_cmd_t c;
    c.cmd = cmd;
    c.entry = entry[IdxW-1:0];
    c.used = used;
    c.pages = pages[SizeW-1:0];
    c.call_end = ce;
    send_cmd(c);
  endtask

  task automatic drain();
    @(negedge clk_i);
    item.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CntW-1:0] data);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  function automatic int rand_pages();
    int p;
    p = $urandom_range(99);
    if (p < 10) return 0;
    if (p < 18) return 65535;
    if (p < 65) return $urandom_range(1, 3000);
    return $urandom_range(0, 65535);
  endfunction

  task automatic random_cmd();
    int p, e;
    p = $urandom_range(99);
    e = $urandom_range(0, 15);
    if (p < 60) begin
      send_fields(CMD_TRACK, e, $urandom_range(99) < 75, rand_pages(),
                  1'($urandom_range(1)));
    end else if (p < 72) begin
      send_fields(CMD_READ, e, 1'($urandom_range(1)), $urandom_range(0, 65535),
                  1'($urandom_range(1)));
    end else if (p < 79) begin
      send_fields(CMD_DROP, e, 1'($urandom_range(1)), $urandom_range(0, 65535),
                  1'($urandom_range(1)));
    end else if (p < 84) begin
      send_fields(CMD_DECAY, e, 1'($urandom_range(1)), $urandom_range(0, 65535),
                  1'($urandom_range(1)));
    end else if (p < 90) begin
      send_fields(CMD_REBAL, e, 1'($urandom_range(1)), $urandom_range(0, 65535),
                  1'($urandom_range(1)));
    end else if (p < 94) begin
      send_fields(CmdW'($urandom_range(5, 7)), $urandom_range(0, 255), 1'($urandom_range(1)),
                  $urandom_range(0, 65535), 1'($urandom_range(1)));
    end else if (p < 97) begin
      e = $urandom_range(0, 255);
      send_fields(CMD_READ, e, 1'($urandom_range(1)), $urandom_range(0, 65535),
                  1'($urandom_range(1)));
    end else begin
      // A wide index is registered and then dropped right away, keeping the table small.
      e = $urandom_range(16, 255);
      send_fields(CMD_TRACK, e, 1'($urandom_range(1)), rand_pages(), 1'($urandom_range(1)));
      send_fields(CMD_DROP, e, 0, 0, 0);
    end
  endtask

  initial begin
    int bud, warm;
    item.valid = 1'b0;
    item.cmd = CMD_TRACK;
    item.entry = '0;
    item.used = 1'b0;
    item.slice_pages = '0;
    item.call_end = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_BUDGET;
    cfg.data = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_fields(CMD_REBAL, 0, 0, 0, 0);
    send_fields(CMD_TRACK, 0, 1, 0, 1);
    send_fields(CMD_TRACK, 255, 1, 65535, 1);
    send_fields(CMD_TRACK, 1, 1, 100, 0);
    send_fields(CMD_TRACK, 1, 1, 7, 1);
    send_fields(CMD_TRACK, 2, 0, 65535, 0);
    send_fields(CMD_READ, 0, 1, 65535, 1);
    send_fields(CMD_READ, 7, 0, 0, 0);
    send_fields(CMD_DROP, 9, 0, 0, 0);
    send_fields(CMD_DECAY, 0, 1, 65535, 1);
    send_fields(3'd5, 255, 1, 65535, 1);
    send_fields(3'd6, 0, 0, 0, 0);
    send_fields(3'd7, 170, 1, 21845, 0);
    drain();
    write_reg(REG_WARMUP, 32'hFFFF0000);
    write_reg(REG_BUDGET, 32'hFF000001);
    send_fields(CMD_TRACK, 1, 1, 0, 0);
    send_fields(CMD_REBAL, 0, 0, 0, 0);
    drain();
    write_reg(REG_BUDGET, 32'h00FFFFFF);
    send_fields(CMD_REBAL, 0, 0, 0, 0);
    send_fields(CMD_DECAY, 0, 0, 0, 0);
    send_fields(CMD_REBAL, 0, 0, 0, 0);
    send_fields(CMD_DROP, 255, 0, 0, 0);
    send_fields(CMD_READ, 255, 0, 0, 0);
    send_fields(CMD_DROP, 1, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin bud = 16777215; warm = 0; end
        1: begin bud = 0; warm = 10; end
        2: begin bud = $urandom_range(1, 150000); warm = $urandom_range(0, 40); end
        3: begin bud = 1; warm = 65535; end
        4: begin bud = $urandom_range(50000, 400000); warm = 3; end
        default: begin bud = $urandom_range(0, 16777215); warm = $urandom_range(0, 200); end
      endcase
      write_reg(REG_BUDGET, {8'($urandom_range(255)), bud[TotW-1:0]});
      write_reg(REG_WARMUP, {16'($urandom_range(65535)), warm[WarmW-1:0]});
      if (ph < 2) begin
        src_pct = 37;
        snk_pct = 64;
      end else if (ph < 4) begin
        src_pct = 64;
        snk_pct = 37;
      end else begin
        src_pct = 0;
        snk_pct = 0;
      end
      for (int k = 0; k < 190; k++) random_cmd();
      drain();
    end

    repeat (300) @(posedge clk_i);
    if (sb.pending() != 0) report("results still awaited at the end");
    if (errors == 0) begin
      $display("PASS hot_slice_pin_selector_core");
    end else begin
      $display("FAIL hot_slice_pin_selector_core");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL hot_slice_pin_selector_core");
    $finish;
  end

endmodule

/* hot_slice_pin_selector_core.f */
src/hsps_pkg.sv
src/hsps_if.sv
src/hsps_ram.sv
src/hsps_ctrl.sv
src/hsps_dp.sv
src/hot_slice_pin_selector_core.sv
tb/hot_slice_pin_selector_core_test.sv
